FILE: sv/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants for the text terminal cursor and scroll engine.
// ----------------------------------------------------------------------------
package tts_pkg;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_SEEK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_COPY,
        ST_ZERO,
        ST_PUT,
        ST_DONE
    } state_t;

    localparam logic [15:0] CHAR_MASK    = 16'h00FF;
    localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
    localparam logic [7:0]  CH_RETURN    = 8'h0D;
    localparam logic [7:0]  CH_BACKSPACE = 8'h08;

    typedef struct packed {
        op_t         operation;
        logic [15:0] cell_entry;
        logic [6:0]  target_column;
        logic [4:0]  target_row;
        logic [3:0]  fill_color;
    } request_t;

    typedef struct packed {
        logic [15:0] read_entry;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
    } result_t;

endpackage

FILE: sv/tts_cell_ram.sv
// ----------------------------------------------------------------------------
// tts_cell_ram
// Character-cell buffer: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module tts_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/tts_cursor_unit.sv
// ----------------------------------------------------------------------------
// tts_cursor_unit
// Next cursor position and cell write for put, and saturated cursor for seek.
// ----------------------------------------------------------------------------
module tts_cursor_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int CW      = 7,
    parameter int RW      = 5,
    parameter int AW      = 11
) (
    input  logic [CW-1:0] col,
    input  logic [RW-1:0] row,
    input  logic [15:0]   entry,
    input  logic [6:0]    target_column,
    input  logic [4:0]    target_row,
    output logic [CW-1:0] put_col,
    output logic [RW-1:0] put_row,
    output logic          put_we,
    output logic [AW-1:0] put_addr,
    output logic [CW-1:0] seek_col,
    output logic [RW-1:0] seek_row
);
    import tts_pkg::*;

    logic [15:0] masked;
    logic [CW-1:0] col_sat;
    logic [CW:0]   col_inc;

    always_comb
    begin
        masked   = entry & CHAR_MASK;
        col_sat  = ({1'b0, col} >= (CW+1)'(COLUMNS)) ? CW'(COLUMNS - 1) : col;
        col_inc  = {1'b0, col_sat} + (CW+1)'(1);
        put_col  = col;
        put_row  = row;
        put_we   = 1'b0;
        put_addr = AW'(AW'(row) * AW'(COLUMNS) + AW'(col_sat));
        case (masked[7:0])
            CH_NEWLINE:
            begin
                put_col = '0;
                put_row = row + RW'(1);
            end
            CH_RETURN:
            begin
                put_col = '0;
            end
            CH_BACKSPACE:
            begin
                if (col != '0)
                begin
                    put_col = col - CW'(1);
                end
            end
            default:
            begin
                put_we = 1'b1;
                if (col_inc >= (CW+1)'(COLUMNS))
                begin
                    put_col = '0;
                    put_row = row + RW'(1);
                end
                else
                begin
                    put_col = CW'(col_inc);
                end
            end
        endcase

        seek_col = ({2'b0, target_column} >= 9'(COLUMNS)) ? CW'(COLUMNS - 1)
                                                          : CW'(target_column);
        seek_row = ({3'b0, target_row} > 8'(ROWS)) ? RW'(ROWS) : RW'(target_row);
    end

endmodule

FILE: sv/text_terminal_cursor_scroll_top.sv
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll_top
// Text terminal engine: cell buffer in a synchronous RAM, cursor and sequencer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals
//  request   in         request_valid, request_ready, request (request_t)
//  result    out        result_valid, result_ready, result (result_t)
//
//  Seek, read and a put that needs no scroll go from the accept in ST_IDLE
//  straight to ST_DONE, which loads the result register.
//  Clear and a put with a pending scroll are paced by the single RAM write
//  port walking every cell: ST_FILL for clear, ST_COPY and ST_ZERO for scroll.
//  After reset a clearing pass zeroes the buffer with request_ready low.
//  A stalled result holds the sequencer only when a second result is ready to
//  be loaded.
module text_terminal_cursor_scroll_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               request_valid,
    output logic               request_ready,
    input  tts_pkg::request_t  request,
    output logic               result_valid,
    input  logic               result_ready,
    output tts_pkg::result_t   result
);
    import tts_pkg::*;

    localparam int N    = COLUMNS * ROWS;
    localparam int CW   = $clog2(COLUMNS);
    localparam int RW   = $clog2(ROWS + 1);
    localparam int AW   = $clog2(N);
    localparam int CNTW = $clog2(N + 1);

    state_t          state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [15:0]     entry_reg, entry_next;
    logic [15:0]     fill_reg, fill_next;
    logic            rd_ok_reg, rd_ok_next;
    logic            result_valid_reg, result_valid_next;
    result_t         result_reg, result_next;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [15:0]     mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [15:0]     mem_rdata;

    logic [15:0]     cu_entry;
    logic [CW-1:0]   put_col, seek_col;
    logic [RW-1:0]   put_row, seek_row;
    logic            put_we;
    logic [AW-1:0]   put_addr;
    logic            req_in_range;
    logic [AW-1:0]   req_addr;

    tts_cell_ram #(
        .DEPTH (N),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    tts_cursor_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CW      (CW),
        .RW      (RW),
        .AW      (AW)
    ) u_cursor (
        .col           (col_reg),
        .row           (row_reg),
        .entry         (cu_entry),
        .target_column (request.target_column),
        .target_row    (request.target_row),
        .put_col       (put_col),
        .put_row       (put_row),
        .put_we        (put_we),
        .put_addr      (put_addr),
        .seek_col      (seek_col),
        .seek_row      (seek_row)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            cnt_reg          <= '0;
            col_reg          <= '0;
            row_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg  <= entry_next;
        fill_reg   <= fill_next;
        rd_ok_reg  <= rd_ok_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        cu_entry     = (state_reg == ST_PUT) ? entry_reg : request.cell_entry;
        req_in_range = ({2'b0, request.target_column} < 9'(COLUMNS)) &&
                       ({3'b0, request.target_row} < 8'(ROWS));
        req_addr     = AW'(AW'(request.target_row) * AW'(COLUMNS)
                           + AW'(request.target_column));

        state_next        = state_reg;
        cnt_next          = cnt_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        entry_next        = entry_reg;
        fill_next         = fill_reg;
        rd_ok_next        = rd_ok_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        request_ready     = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = AW'(cnt_reg);
        mem_wdata         = fill_reg;
        mem_re            = 1'b0;
        mem_raddr         = req_addr;

        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (cnt_reg == CNTW'(N - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            ST_IDLE:
            begin
                request_ready = 1'b1;
                if (request_valid)
                begin
                    rd_ok_next = 1'b0;
                    case (request.operation)
                        OP_PUT:
                        begin
                            if (row_reg >= RW'(ROWS))
                            begin
                                entry_next = request.cell_entry;
                                row_next   = RW'(ROWS - 1);
                                cnt_next   = '0;
                                state_next = ST_COPY;
                            end
                            else
                            begin
                                mem_we     = put_we;
                                mem_waddr  = put_addr;
                                mem_wdata  = request.cell_entry;
                                col_next   = put_col;
                                row_next   = put_row;
                                state_next = ST_DONE;
                            end
                        end
                        OP_SEEK:
                        begin
                            col_next   = seek_col;
                            row_next   = seek_row;
                            state_next = ST_DONE;
                        end
                        OP_CLEAR:
                        begin
                            fill_next  = {request.fill_color, request.fill_color, 8'h00};
                            cnt_next   = '0;
                            state_next = ST_FILL;
                        end
                        default:
                        begin
                            mem_re     = 1'b1;
                            rd_ok_next = req_in_range;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                if (cnt_reg == CNTW'(N - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            ST_COPY:
            begin
                mem_raddr = AW'(cnt_reg + CNTW'(COLUMNS));
                mem_re    = (cnt_reg != CNTW'(N - COLUMNS));
                mem_we    = (cnt_reg != '0);
                mem_waddr = AW'(cnt_reg - CNTW'(1));
                mem_wdata = mem_rdata;
                if (cnt_reg == CNTW'(N - COLUMNS))
                begin
                    state_next = ST_ZERO;
                end
                else
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            ST_ZERO:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (cnt_reg == CNTW'(N - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_PUT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            ST_PUT:
            begin
                mem_we     = put_we;
                mem_waddr  = put_addr;
                mem_wdata  = entry_reg;
                col_next   = put_col;
                row_next   = put_row;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.read_entry    = rd_ok_reg ? mem_rdata : 16'h0000;
                    result_next.cursor_column = 7'(col_reg);
                    result_next.cursor_row    = 5'(row_reg);
                    result_valid_next         = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
